// File: rtl/pfhi_pkg.sv
// Package for the polygon fan height interpolator: payload structs, sizes,
// controller states and the command/status structs. No dependencies.
package pfhi_pkg;

  localparam int MAX_VERTS = 16;
  localparam int IDX_W     = $clog2(MAX_VERTS);
  localparam int CNT_W     = $clog2(MAX_VERTS + 1);
  localparam int SUM_W     = 16 + CNT_W;
  localparam int DOT_W     = 35;
  localparam int L3_W      = 37;
  localparam int HALF_W    = 17;
  localparam int ACC_W     = 56;
  localparam int QBITS     = 16;
  localparam int DSR_W     = DOT_W + QBITS - 1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic CFG_CENTER_X = 1'b0;
  localparam logic CFG_CENTER_Y = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [15:0] vertex_height_in;
    logic        last_vertex;
  } in_data_t;

  typedef struct packed {
    logic [15:0] height_out;
    logic        hit;
  } out_data_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CINIT, S_READ, S_DET, S_L1, S_L2, S_TEST, S_MAC, S_QINIT, S_DIV, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    DOT_DET, DOT_L1, DOT_L2
  } dot_sel_t;

  typedef struct packed {
    logic             load;
    logic             qcap;
    logic             rd;
    logic             dot_en;
    dot_sel_t         dot_sel;
    logic             mac_en;
    logic [2:0]       mac_step;
    logic             div_start;
    logic             div_center;
    logic             div_step;
    logic             fin_center;
    logic             res_load;
    logic             res_hit;
    logic [IDX_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic             closed;
    logic             count_nz;
    logic             last_tri;
    logic             in_tri;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } status_t;

endpackage

// File: rtl/pfhi_datapath.sv
// Datapath: vertex ring memory, fan dot products, inside test, weighted sum
// and shared restoring divider, plus the output register. Uses pfhi_pkg.
module pfhi_datapath import pfhi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  in_data_t    in_data,
  input  cmd_t        cmd,
  output status_t     st,
  input  logic        out_stall,
  output logic        out_valid,
  output out_data_t   out_data
);

  logic [15:0] mem_x [MAX_VERTS];
  logic [15:0] mem_y [MAX_VERTS];
  logic [15:0] mem_h [MAX_VERTS];

  logic [15:0]      center_x, center_y;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] hsum;
  logic [15:0]      chgt;
  logic             closed;
  logic [15:0]      px, py;
  logic [15:0]      x1, y1, h1, x2, y2, h2;
  logic signed [DOT_W-1:0] det, l1, l2, l3;
  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [QBITS-1:0] q;
  logic             neg;

  // load bookkeeping
  logic [CNT_W-1:0] base_cnt;
  logic [SUM_W-1:0] base_sum;
  assign base_cnt = closed ? '0 : count;
  assign base_sum = closed ? '0 : hsum;

  // cyclic successor of k
  logic [IDX_W-1:0] e_idx;
  logic [CNT_W-1:0] k_inc;
  assign k_inc = CNT_W'(cmd.k) + CNT_W'(1);
  assign e_idx = (k_inc == count) ? '0 : k_inc[IDX_W-1:0];

  // offsets from the center, 17 bit signed
  logic signed [16:0] ax, ay, nay, bx, by, dpx, dpy;
  assign ax  = $signed({x1[15], x1}) - $signed({center_x[15], center_x});
  assign ay  = $signed({y1[15], y1}) - $signed({center_y[15], center_y});
  assign nay = $signed({center_y[15], center_y}) - $signed({y1[15], y1});
  assign bx  = $signed({center_x[15], center_x}) - $signed({x2[15], x2});
  assign by  = $signed({y2[15], y2}) - $signed({center_y[15], center_y});
  assign dpx = $signed({px[15], px}) - $signed({center_x[15], center_x});
  assign dpy = $signed({py[15], py}) - $signed({center_y[15], center_y});

  logic signed [16:0] oa0, ob0, oa1, ob1;
  always_comb begin
    case (cmd.dot_sel)
      DOT_DET: begin oa0 = by;  ob0 = ax;  oa1 = bx; ob1 = ay;  end
      DOT_L1:  begin oa0 = by;  ob0 = dpx; oa1 = bx; ob1 = dpy; end
      DOT_L2:  begin oa0 = nay; ob0 = dpx; oa1 = ax; ob1 = dpy; end
      default: begin oa0 = by;  ob0 = ax;  oa1 = bx; ob1 = ay;  end
    endcase
  end

  logic signed [33:0] p0, p1;
  logic signed [DOT_W-1:0] dot;
  assign p0  = oa0 * ob0;
  assign p1  = oa1 * ob1;
  assign dot = DOT_W'(p0) + DOT_W'(p1);

  // inside test on the three unnormalized weights
  logic signed [L3_W-1:0] det_e, l1_e, l2_e, l3c;
  assign det_e = L3_W'(det);
  assign l1_e  = L3_W'(l1);
  assign l2_e  = L3_W'(l2);
  assign l3c   = det_e - l1_e - l2_e;
  assign st.in_tri = (det > 0) && (l1 >= 0) && (l1_e <= det_e) && (l2 >= 0) &&
                     (l2_e <= det_e) && (l3c >= 0) && (l3c <= det_e);

  // weighted sum, one 18x16 partial product a cycle
  logic signed [DOT_W-1:0] w;
  logic signed [15:0]      hh;
  logic [HALF_W-1:0]       part;
  logic signed [HALF_W+16:0] mprod;
  logic signed [ACC_W-1:0] term;
  always_comb begin
    case (cmd.mac_step[2:1])
      2'd0:    begin w = l1; hh = $signed(h1);   end
      2'd1:    begin w = l2; hh = $signed(h2);   end
      default: begin w = l3; hh = $signed(chgt); end
    endcase
    part  = cmd.mac_step[0] ? w[2*HALF_W-1:HALF_W] : w[HALF_W-1:0];
    mprod = $signed({1'b0, part}) * hh;
    term  = cmd.mac_step[0] ? (ACC_W'(mprod) <<< HALF_W) : ACC_W'(mprod);
  end

  // divider operands
  logic signed [ACC_W-1:0] dvd;
  logic [DOT_W-1:0]        dvs;
  assign dvd = cmd.div_center ? ACC_W'($signed(hsum)) : acc;
  assign dvs = cmd.div_center ? DOT_W'(count) : DOT_W'(det);

  logic [QBITS-1:0] qs;
  assign qs = neg ? (QBITS'(0) - q) : q;

  logic [ACC_W-1:0] dsr_e;
  assign dsr_e = ACC_W'(dsr);

  assign st.closed   = closed;
  assign st.count    = count;
  assign st.count_nz = (count != '0);
  assign st.last_tri = (k_inc == count);
  assign st.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x  <= '0;
      center_y  <= '0;
      count     <= '0;
      hsum      <= '0;
      chgt      <= '0;
      closed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER_X: center_x <= cfg_data;
          CFG_CENTER_Y: center_y <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        count  <= base_cnt;
        hsum   <= base_sum;
        closed <= 1'b0;
        if (base_cnt < CNT_W'(MAX_VERTS)) begin
          count <= base_cnt + CNT_W'(1);
          hsum  <= base_sum + SUM_W'($signed(in_data.vertex_height_in));
        end
        if (in_data.last_vertex) closed <= 1'b1;
      end
      if (cmd.fin_center) chgt <= qs;
      if (cmd.res_load) begin
        out_valid           <= 1'b1;
        out_data.hit        <= cmd.res_hit;
        out_data.height_out <= cmd.res_hit ? qs : 16'd0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ring memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.load && base_cnt < CNT_W'(MAX_VERTS)) begin
      mem_x[base_cnt[IDX_W-1:0]] <= in_data.coord_x;
      mem_y[base_cnt[IDX_W-1:0]] <= in_data.coord_y;
      mem_h[base_cnt[IDX_W-1:0]] <= in_data.vertex_height_in;
    end
    if (cmd.rd) begin
      x1 <= mem_x[cmd.k];
      y1 <= mem_y[cmd.k];
      h1 <= mem_h[cmd.k];
      x2 <= mem_x[e_idx];
      y2 <= mem_y[e_idx];
      h2 <= mem_h[e_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.qcap) begin
      px <= in_data.coord_x;
      py <= in_data.coord_y;
    end
    if (cmd.dot_en) begin
      case (cmd.dot_sel)
        DOT_DET: det <= dot;
        DOT_L1:  l1  <= dot;
        DOT_L2:  l2  <= dot;
        default: det <= dot;
      endcase
    end
    if (st.in_tri) l3 <= DOT_W'(l3c);
    if (cmd.mac_en) acc <= ((cmd.mac_step == 3'd0) ? ACC_W'(0) : acc) + term;
    if (cmd.div_start) begin
      neg <= dvd < 0;
      rem <= (dvd < 0) ? ACC_W'(-dvd) : ACC_W'(dvd);
      dsr <= {dvs, (QBITS-1)'(0)};
      q   <= '0;
    end else if (cmd.div_step) begin
      dsr <= dsr >> 1;
      if (rem >= dsr_e) begin
        rem <= rem - dsr_e;
        q   <= {q[QBITS-2:0], 1'b1};
      end else begin
        q   <= {q[QBITS-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/pfhi_ctrl.sv
// Controller: sequences loads, the fan walk, the weighted sum and the divider.
// Uses pfhi_pkg; drives commands into pfhi_datapath.
module pfhi_ctrl import pfhi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_data_t in_data,
  output logic     in_stall,
  input  status_t  st,
  output cmd_t     cmd
);

  state_t           state, state_next;
  logic [IDX_W-1:0] k;
  logic [3:0]       cnt;
  logic             qhit, cmode;
  logic             acc_in;

  assign in_stall = (state != S_IDLE);
  assign acc_in   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc_in) begin
          if (in_data.req_type == REQ_LOAD) begin
            if (in_data.last_vertex) state_next = S_CINIT;
          end else if (st.closed && st.count_nz) begin
            state_next = S_READ;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_CINIT: state_next = S_DIV;
      S_READ:  state_next = S_DET;
      S_DET:   state_next = S_L1;
      S_L1:    state_next = S_L2;
      S_L2:    state_next = S_TEST;
      S_TEST: begin
        if (st.in_tri)        state_next = S_MAC;
        else if (st.last_tri) state_next = S_FIN;
        else                  state_next = S_READ;
      end
      S_MAC:   if (cnt == 4'd5) state_next = S_QINIT;
      S_QINIT: state_next = S_DIV;
      S_DIV:   if (cnt == 4'(QBITS - 1)) state_next = S_FIN;
      S_FIN:   if (cmode || st.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.k          = k;
    cmd.mac_step   = cnt[2:0];
    cmd.div_center = cmode;
    cmd.res_hit    = qhit;
    cmd.dot_sel    = DOT_DET;
    case (state)
      S_IDLE: begin
        cmd.load = acc_in && (in_data.req_type == REQ_LOAD);
        cmd.qcap = acc_in && (in_data.req_type == REQ_QUERY);
      end
      S_CINIT: cmd.div_start = 1'b1;
      S_READ:  cmd.rd = 1'b1;
      S_DET:   begin cmd.dot_en = 1'b1; cmd.dot_sel = DOT_DET; end
      S_L1:    begin cmd.dot_en = 1'b1; cmd.dot_sel = DOT_L1;  end
      S_L2:    begin cmd.dot_en = 1'b1; cmd.dot_sel = DOT_L2;  end
      S_MAC:   cmd.mac_en = 1'b1;
      S_QINIT: cmd.div_start = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_FIN: begin
        cmd.fin_center = cmode;
        cmd.res_load   = !cmode && st.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      cnt   <= '0;
      qhit  <= 1'b0;
      cmode <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          k    <= '0;
          qhit <= 1'b0;
          if (acc_in) cmode <= (in_data.req_type == REQ_LOAD);
        end
        S_TEST: begin
          cnt <= '0;
          if (st.in_tri) qhit <= 1'b1;
          else           k    <= k + IDX_W'(1);
        end
        S_MAC:   cnt <= cnt + 4'd1;
        S_CINIT: cnt <= '0;
        S_QINIT: cnt <= '0;
        S_DIV:   cnt <= cnt + 4'd1;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/polygon_fan_height_interpolator.sv
// Top level of the polygon fan height interpolator.
// Depends on pfhi_pkg, pfhi_ctrl and pfhi_datapath.
//
// Usage:
//   in channel  (in_valid / in_stall / in_data): one transaction is a vertex
//     load (req_type 0) or a point query (req_type 1).
//   out channel (out_valid / out_stall / out_data): one transaction per query.
//   cfg port (cfg_we / cfg_index / cfg_data): center_x at 0, center_y at 1,
//     written while the block is idle.
// Operation:
//   vertex load: a load not marked last does not stall the input; a load marked
//     last adds a center mean division through the shared divider.
//   query: per fan triangle walked, a memory read, three dot products and
//     an inside test; when a triangle hits, the weighted sum and then the
//     divider. The input stays stalled until the query or division is done.
//     The fan walk and the 16-step restoring divider set the query time.
//   A miss or a query on an open ring gives hit 0 and height 0.
// Reset: synchronous; clears the ring (count 0, open), center height and
//   the center registers. Ring memory contents are not cleared.
// Stall: the result sits in an output register; the block takes the next
//   transaction while it waits and blocks only when a newer result is ready.
module polygon_fan_height_interpolator import pfhi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_data_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_data_t   out_data
);

  cmd_t    cmd;
  status_t st;

  pfhi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  pfhi_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a miss always reports zero height
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.height_out == 16'd0)
    else $error("miss with nonzero height");

  // an accepted query keeps the input side busy next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.req_type == REQ_QUERY |=> in_stall)
    else $error("query did not occupy the block");

  // the ring never holds more than its capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    st.count <= CNT_W'(MAX_VERTS))
    else $error("vertex count overflow");

endmodule
